@@ src/blen_pkg.sv @@
// shared constants and codes for the bounded list engine
package blen_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	localparam int OPCODE_W = 3;
	localparam int INDEX_W  = 6;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int FIDX_W   = 6;
	localparam int RVAL_W   = 32;
	localparam int LENGTH_W = 7;

	localparam int IN_FIELDS_W  = OPCODE_W + INDEX_W + VALUE_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STATUS_W + 1 + FIDX_W + RVAL_W + LENGTH_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	localparam opcode_t OP_APPEND    = 3'd0;
	localparam opcode_t OP_OVERWRITE = 3'd1;
	localparam opcode_t OP_REMOVE    = 3'd2;
	localparam opcode_t OP_READ      = 3'd3;
	localparam opcode_t OP_FIND      = 3'd4;
	localparam opcode_t OP_CLEAR     = 3'd5;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_RANGE   = 2'd2;
	localparam status_t ST_MISSING = 2'd3;

endpackage

@@ src/blen_ram.sv @@
// list entry storage: one write port, one registered read port
module blen_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ src/bounded_list_engine_unit.sv @@
// bounded list engine top: request sequencer, entry walk and result register
// append, overwrite, clear, full and index errors answer from the idle state; read goes through the read state
// find walks the entries through one compare, until a match or the end of the list
// remove adds a shift pass of one entry per cycle, up to the end of the list
// one request at a time; the next is taken once the result transfer is done
// reset clears the length and the sequencer; entry storage is not cleared
module bounded_list_engine_unit
	import blen_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // opcode, index, value
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // status, found, found_index, read_value, length
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic             pend_q;
	logic [CNT_W-1:0] pend_pos_q;
	opcode_t          op_q;
	word_t            value_q;

	logic                m_valid_q;
	status_t             status_q;
	logic                found_q;
	logic [FIDX_W-1:0]   fidx_q;
	logic [RVAL_W-1:0]   rval_q;
	logic [LENGTH_W-1:0] length_q;

	logic             accept;
	opcode_t          in_op;
	logic [CNT_W-1:0] in_idx;
	word_t            in_value;
	logic             in_range;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	word_t            ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	word_t            ram_rdata;

	logic             more;
	logic             hit;

	assign s_tready = (state_q == S_IDLE) && !m_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign in_op    = s_tdata[OPCODE_W-1:0];
	assign in_idx   = CNT_W'(s_tdata[OPCODE_W +: INDEX_W]);
	assign in_value = DATA_WIDTH'(s_tdata[OPCODE_W+INDEX_W +: VALUE_W]);
	assign in_range = in_idx < count_q;
	assign more     = ptr_q < count_q;
	assign hit      = pend_q && (ram_rdata == value_q);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TDATA_W'({length_q, rval_q, fidx_q, found_q, status_q});

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = in_value;
		ram_raddr = ptr_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = in_idx[IDX_W-1:0];
				if (accept && in_op == OP_APPEND && count_q < CNT_W'(CAPACITY)) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[IDX_W-1:0];
				end
				if (accept && in_op == OP_OVERWRITE && in_range) begin
					ram_we    = 1'b1;
					ram_waddr = in_idx[IDX_W-1:0];
				end
			end
			S_SHIFT: begin
				ram_we    = pend_q;
				ram_waddr = IDX_W'(pend_pos_q - CNT_W'(1));
				ram_wdata = ram_rdata;
			end
			default: begin
			end
		endcase
	end

	blen_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(DATA_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			ptr_q      <= '0;
			pend_q     <= 1'b0;
			pend_pos_q <= '0;
			op_q       <= OP_APPEND;
			value_q    <= '0;
			m_valid_q  <= 1'b0;
			status_q   <= ST_OK;
			found_q    <= 1'b0;
			fidx_q     <= '0;
			rval_q     <= '0;
			length_q   <= '0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= in_op;
						value_q  <= in_value;
						ptr_q    <= '0;
						pend_q   <= 1'b0;
						status_q <= ST_OK;
						found_q  <= 1'b0;
						fidx_q   <= '0;
						rval_q   <= '0;
						length_q <= LENGTH_W'(count_q);
						unique case (in_op)
							OP_APPEND: begin
								m_valid_q <= 1'b1;
								if (count_q < CNT_W'(CAPACITY)) begin
									count_q  <= count_q + CNT_W'(1);
									length_q <= LENGTH_W'(count_q + CNT_W'(1));
								end else begin
									status_q <= ST_FULL;
								end
							end
							OP_OVERWRITE: begin
								m_valid_q <= 1'b1;
								if (!in_range) begin
									status_q <= ST_RANGE;
								end
							end
							OP_READ: begin
								if (in_range) begin
									state_q <= S_READ;
								end else begin
									status_q  <= ST_RANGE;
									m_valid_q <= 1'b1;
								end
							end
							OP_REMOVE, OP_FIND: begin
								state_q <= S_SCAN;
							end
							OP_CLEAR: begin
								count_q   <= '0;
								length_q  <= '0;
								m_valid_q <= 1'b1;
							end
							default: begin
								m_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					rval_q    <= RVAL_W'(ram_rdata);
					m_valid_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				S_SCAN: begin
					priority if (hit) begin
						found_q <= 1'b1;
						fidx_q  <= FIDX_W'(pend_pos_q);
						if (op_q == OP_FIND) begin
							m_valid_q <= 1'b1;
							state_q   <= S_IDLE;
						end else begin
							ptr_q   <= pend_pos_q + CNT_W'(1);
							pend_q  <= 1'b0;
							state_q <= S_SHIFT;
						end
					end else if (!more) begin
						status_q  <= ST_MISSING;
						pend_q    <= 1'b0;
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						ptr_q      <= ptr_q + CNT_W'(1);
						pend_q     <= 1'b1;
						pend_pos_q <= ptr_q;
					end
				end
				S_SHIFT: begin
					if (more) begin
						ptr_q      <= ptr_q + CNT_W'(1);
						pend_q     <= 1'b1;
						pend_pos_q <= ptr_q;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							count_q   <= count_q - CNT_W'(1);
							length_q  <= LENGTH_W'(count_q - CNT_W'(1));
							m_valid_q <= 1'b1;
							state_q   <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list length above capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE) || m_valid_q)
		else $error("request accepted with no work or result");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && found_q |-> status_q == ST_OK)
		else $error("match reported with error status");

	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !m_valid_q)
		else $error("result pending while sequencer busy");
`endif

endmodule
